>>> rtl/core/mh64_pkg.sv
`timescale 1ns / 1ps

package mh64_pkg;

	localparam logic [63:0] HASH_SEED = 64'h9368_1D62_5531_3A99;
	localparam logic [63:0] MUL_WORD  = 64'hFF51_AFD7_ED55_8CCD;
	localparam logic [63:0] MUL_HASH  = 64'hC4CE_B9FE_1A85_EC53;
	localparam int unsigned XS_SHIFT  = 33;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MLL,
		ST_MLH,
		ST_MHL,
		ST_MEND,
		ST_FPREP
	} state_t;

	typedef enum logic [1:0] {
		PH_ABS1,
		PH_ABS2,
		PH_FIN
	} phase_t;

	// Partial product currently issued to the shared 32x32 multiplier
	typedef enum logic [1:0] {
		MOP_NONE,
		MOP_LL,
		MOP_LH,
		MOP_HL
	} mop_t;

	// Where the finished product goes
	typedef enum logic [1:0] {
		END_NONE,
		END_ABS1,
		END_ABS2,
		END_FIN
	} endop_t;

	typedef struct packed {
		logic   accept;
		mop_t   mop;
		logic   sel_mh;
		endop_t endop;
		logic   fin_prep;
	} cmd_t;

	typedef struct packed {
		logic need_absorb;
		logic out_busy;
		logic lane_zero;
	} status_t;

	function automatic logic [63:0] xorshift(input logic [63:0] x);
		return x ^ (x >> XS_SHIFT);
	endfunction

endpackage

>>> rtl/core/mh64_ctrl.sv
`timescale 1ns / 1ps

module mh64_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last,
	input  mh64_pkg::status_t sts,
	output logic             in_stall,
	output mh64_pkg::cmd_t   cmd
);
	import mh64_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   fin_pend_q, fin_pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_ABS1;
			fin_pend_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			fin_pend_q <= fin_pend_d;
		end
	end

	// Next state
	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		fin_pend_d = fin_pend_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.need_absorb) begin
						phase_d    = PH_ABS1;
						fin_pend_d = last;
						state_d    = ST_MLL;
					end else if (last) begin
						state_d = ST_FPREP;
					end
				end
			end
			ST_MLL:  state_d = ST_MLH;
			ST_MLH:  state_d = ST_MHL;
			ST_MHL:  state_d = ST_MEND;
			ST_MEND: begin
				unique case (phase_q)
					PH_ABS1: begin
						phase_d = PH_ABS2;
						state_d = ST_MLL;
					end
					PH_ABS2: state_d = fin_pend_q ? ST_FPREP : ST_IDLE;
					PH_FIN: begin
						if (!sts.out_busy) begin
							state_d = ST_IDLE;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_FPREP: begin
				phase_d    = PH_FIN;
				fin_pend_d = 1'b0;
				state_d    = ST_MLL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.mop      = MOP_NONE;
		cmd.endop    = END_NONE;
		cmd.sel_mh   = (phase_q == PH_ABS2);
		in_stall     = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:  cmd.accept   = in_valid;
			ST_MLL:   cmd.mop      = MOP_LL;
			ST_MLH:   cmd.mop      = MOP_LH;
			ST_MHL:   cmd.mop      = MOP_HL;
			ST_MEND: begin
				unique case (phase_q)
					PH_ABS1: cmd.endop = END_ABS1;
					PH_ABS2: cmd.endop = END_ABS2;
					PH_FIN:  cmd.endop = sts.out_busy ? END_NONE : END_FIN;
					default: cmd.endop = END_NONE;
				endcase
			end
			ST_FPREP: cmd.fin_prep = 1'b1;
			default:  cmd.accept   = 1'b0;
		endcase
	end

endmodule

>>> rtl/core/mh64_dp.sv
`timescale 1ns / 1ps

module mh64_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mh64_pkg::cmd_t    cmd,
	input  logic [7:0]        data_byte,
	input  logic              byte_valid,
	input  logic              last,
	input  logic              out_stall,
	output mh64_pkg::status_t sts,
	output logic              out_valid,
	output logic [63:0]       digest
);
	import mh64_pkg::*;

	logic [63:0] acc_q;
	logic [2:0]  lane_q;
	logic [63:0] total_q;
	logic [63:0] hash_q;
	logic [63:0] work_q;
	logic [63:0] prod_q;
	logic [63:0] p_s1;
	logic [63:0] digest_q;
	logic        out_valid_q;

	logic [63:0] word_next;
	logic [2:0]  lane_next;
	logic        word_full;
	logic [63:0] mconst;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [63:0] mul_r;

	// Byte packing, little-endian
	assign word_next = byte_valid ? (acc_q | ({56'b0, data_byte} << {lane_q, 3'b000})) : acc_q;
	assign lane_next = byte_valid ? lane_q + 3'd1 : lane_q;
	assign word_full = byte_valid && (lane_q == 3'd7);

	assign sts.need_absorb = word_full || (last && (lane_next != 3'd0));
	assign sts.out_busy    = out_valid_q && out_stall;
	assign sts.lane_zero   = (lane_q == 3'd0);

	// Shared 32x32 multiplier, low 64 bits of work_q * constant over three products
	assign mconst = cmd.sel_mh ? MUL_HASH : MUL_WORD;
	always_comb begin
		mul_a = work_q[31:0];
		mul_b = mconst[31:0];
		unique case (cmd.mop)
			MOP_LH:  mul_b = mconst[63:32];
			MOP_HL:  mul_a = work_q[63:32];
			default: mul_b = mconst[31:0];
		endcase
	end
	assign mul_p = mul_a * mul_b;
	assign mul_r = prod_q + {p_s1[31:0], 32'b0};

	always_ff @(posedge clk) begin
		if (cmd.mop != MOP_NONE) begin
			p_s1 <= mul_p;
		end
		if (cmd.mop == MOP_LH) begin
			prod_q <= p_s1;
		end else if (cmd.mop == MOP_HL) begin
			prod_q <= mul_r;
		end
	end

	// Working operand and digest
	always_ff @(posedge clk) begin
		if (cmd.accept && sts.need_absorb) begin
			work_q <= word_next;
		end else if (cmd.endop == END_ABS1) begin
			work_q <= hash_q ^ xorshift(mul_r);
		end else if (cmd.fin_prep) begin
			work_q <= xorshift(hash_q ^ total_q);
		end
		if (cmd.endop == END_FIN) begin
			digest_q <= xorshift(mul_r);
		end
	end

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			lane_q      <= '0;
			total_q     <= '0;
			hash_q      <= HASH_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				acc_q  <= (sts.need_absorb || last) ? 64'd0 : word_next;
				lane_q <= last ? 3'd0 : lane_next;
				if (byte_valid) begin
					total_q <= total_q + 64'd1;
				end
			end
			if (cmd.endop == END_ABS2) begin
				hash_q <= xorshift(mul_r);
			end
			if (cmd.endop == END_FIN) begin
				hash_q      <= HASH_SEED;
				total_q     <= '0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign digest    = digest_q;

endmodule

>>> rtl/core/murmur_style_hash64.sv
`timescale 1ns / 1ps
// Streaming 64-bit hash over a byte message.
// Input channel: in_valid / in_stall with data_byte, byte_valid, last. One item
//   carries at most one message byte; an item with last set closes the message.
//   An item with byte_valid low and last low changes nothing; byte_valid low with
//   last high finalizes whatever has arrived (an empty message is allowed).
// Output channel: out_valid / out_stall with digest, one item per message.
// Word mix: a byte that neither completes a word nor closes the message is taken
//   without holding the input. A byte that completes an eight-byte word holds
//   the input while the word mix runs two 64-bit multiplies, each as three 32x32
//   partial products on one shared multiplier.
// Finalize mixes any open partial word, then one more multiply forms the digest.
// Reset (arst_n low, asynchronous) returns the hash to its seed, clears the byte
//   count and packing state and drops any pending digest.
// A stalled digest holds in its output register; the input side keeps taking
//   bytes, and only the end of the next finalize waits for the slot to drain.
module murmur_style_hash64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest
);
	import mh64_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// Sequencer: byte intake, two-multiply word mix, finalize
	mh64_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Packing, hash state, shared multiplier and output register
	mh64_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.out_stall  (out_stall),
		.sts        (sts),
		.out_valid  (out_valid),
		.digest     (digest)
	);

	// A digest only appears right after the input was held
	a_digest_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("digest raised without a finalize sequence");

	// A completed or final partial word must block the next byte
	a_absorb_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && sts.need_absorb) |=> in_stall)
		else $error("byte accepted while a word mix is pending");

	// Finalize fills the output slot and leaves packing at lane zero
	a_fin_output: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.endop == END_FIN) |=> (out_valid && sts.lane_zero))
		else $error("finalize did not produce a digest");

endmodule
